// ===== rtl/jer_pkg.sv =====
// Shared constants, types and helpers for the jitter entropy ring whitener.
package jer_pkg;

	localparam int POOL_DEPTH = 1024;
	localparam int IDX_W      = $clog2(POOL_DEPTH);

	localparam logic [31:0] LCG_MULT = 32'd1103515245;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_wr;     // write zero at the clearing counter
		logic acc_upd;    // fold the sample into the accumulator
		logic rd_wi;      // read the pool entry at the write index
		logic tick_wr;    // write back the folded byte, advance write index
		logic rd_ri;      // read the pool entry at the read index, multiply
		logic rd_load;    // finish a read: new whitener and result
		logic empty_load; // load an invalid result for an empty ring
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic sample_nz;
		logic ring_full;
		logic ring_empty;
		logic phase_wrap;
		logic out_free;
	} stat_t;

	function automatic idx_t ring_next(idx_t i);
		idx_t n;
		n = i + idx_t'(1);
		if (i == idx_t'(POOL_DEPTH - 1)) begin
			n = '0;
		end
		return n;
	endfunction

endpackage

// ===== rtl/jer_item_if.sv =====
// Input channel: one tick or read transaction.
interface jer_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] sample_count;

	modport source (output valid, output operation, output sample_count, input ready);
	modport sink (input valid, input operation, input sample_count, output ready);
endinterface

// ===== rtl/jer_result_if.sv =====
// Output channel: one whitened byte transaction.
interface jer_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;

	modport source (output valid, output data_byte, output byte_valid, input ready);
	modport sink (input valid, input data_byte, input byte_valid, output ready);
endinterface

// ===== rtl/jitter_entropy_ring_whitener.sv =====
// Top level of the jitter entropy ring whitener.
// A tick ends on acceptance, or in ST_TICK_WR when it folds a byte into the pool.
// A read of a non-empty ring reads the pool and multiplies on acceptance, then the result
// register is loaded in ST_RD_OUT, which waits until the output is free.
// Items are taken one at a time; item_ready is high only in the idle state.
// After reset a clearing pass zeroes the whole pool, and no item is accepted then.
module jitter_entropy_ring_whitener (
	input logic         clk,
	input logic         arst_n,
	jer_item_if.sink    item,
	jer_result_if.source result
);
	import jer_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	jer_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.operation  (item.operation),
		.stat       (stat),
		.item_ready (item.ready),
		.cmd        (cmd)
	);

	jer_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample_count (item.sample_count),
		.out_ready    (result.ready),
		.stat         (stat),
		.out_valid    (result.valid),
		.data_byte    (result.data_byte),
		.byte_valid   (result.byte_valid)
	);

endmodule

// ===== rtl/jer_ctrl.sv =====
// Controller state machine for the entropy ring: clearing, ticks and reads.
module jer_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          operation,
	input  jer_pkg::stat_t stat,
	output logic          item_ready,
	output jer_pkg::cmd_t  cmd
);
	import jer_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR     = 5'b00001,
		ST_IDLE      = 5'b00010,
		ST_TICK_WR   = 5'b00100,
		ST_RD_OUT    = 5'b01000,
		ST_EMPTY_OUT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_ready && item_valid;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_TICK) begin
						// Zero samples and ticks on a full ring leave everything alone.
						if (stat.sample_nz && !stat.ring_full) begin
							cmd.acc_upd = 1'b1;
							if (stat.phase_wrap) begin
								cmd.rd_wi = 1'b1;
								state_d   = ST_TICK_WR;
							end
						end
					end else if (stat.ring_empty) begin
						state_d = ST_EMPTY_OUT;
					end else begin
						cmd.rd_ri = 1'b1;
						state_d   = ST_RD_OUT;
					end
				end
			end
			ST_TICK_WR: begin
				cmd.tick_wr = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_RD_OUT: begin
				if (stat.out_free) begin
					cmd.rd_load = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_EMPTY_OUT: begin
				if (stat.out_free) begin
					cmd.empty_load = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/jer_datapath.sv =====
// Datapath: pool memory, ring indices, fold accumulator, whitener and result register.
module jer_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  jer_pkg::cmd_t  cmd,
	input  logic [31:0]   sample_count,
	input  logic          out_ready,
	output jer_pkg::stat_t stat,
	output logic          out_valid,
	output logic [7:0]    data_byte,
	output logic          byte_valid
);
	import jer_pkg::*;

	logic [7:0]  pool [POOL_DEPTH];
	logic [7:0]  rdata_q;
	idx_t        clr_q;
	idx_t        wi_q;
	idx_t        ri_q;
	logic [15:0] acc_q;
	logic [1:0]  phase_q;
	logic [31:0] whitener_q;
	logic [31:0] prod_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_bv_q;

	logic        mem_we;
	logic        mem_re;
	idx_t        waddr;
	idx_t        raddr;
	logic [7:0]  wdata;
	logic [31:0] prod_d;
	logic [31:0] wh_next;

	assign mem_we  = cmd.clr_wr || cmd.tick_wr;
	assign mem_re  = cmd.rd_wi || cmd.rd_ri;
	assign waddr   = cmd.clr_wr ? clr_q : wi_q;
	assign wdata   = cmd.clr_wr ? 8'h00 : (rdata_q ^ acc_q[7:0]);
	assign raddr   = cmd.rd_wi ? wi_q : ri_q;
	assign prod_d  = whitener_q * LCG_MULT;
	assign wh_next = prod_q ^ {24'h000000, rdata_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pool[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= pool[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_ri) begin
			prod_q <= prod_d;
		end
		if (cmd.rd_load) begin
			out_byte_q <= wh_next[7:0];
			out_bv_q   <= 1'b1;
		end else if (cmd.empty_load) begin
			out_byte_q <= 8'h00;
			out_bv_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			wi_q        <= '0;
			ri_q        <= '0;
			acc_q       <= '0;
			phase_q     <= '0;
			whitener_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= ring_next(clr_q);
			end
			if (cmd.acc_upd) begin
				acc_q   <= {acc_q[13:0], 2'b00} ^ sample_count[15:0];
				phase_q <= phase_q + 2'd1;
			end
			if (cmd.tick_wr) begin
				wi_q <= ring_next(wi_q);
			end
			if (cmd.rd_load) begin
				whitener_q <= wh_next;
				ri_q       <= ring_next(ri_q);
			end
			if (cmd.rd_load || cmd.empty_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.clr_last   = (clr_q == idx_t'(POOL_DEPTH - 1));
	assign stat.sample_nz  = (sample_count != 32'd0);
	assign stat.ring_full  = (ring_next(wi_q) == ri_q);
	assign stat.ring_empty = (wi_q == ri_q);
	assign stat.phase_wrap = (phase_q == 2'd3);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign data_byte  = out_byte_q;
	assign byte_valid = out_bv_q;

endmodule
